// ===== src/crc_pkg.sv =====
// Shared types and constants of the Chinese remainder combiner.
// Holds the transfer payload structs, the sequencer states and the divider interface.
// No dependencies.
`default_nettype none
package crc_pkg;

  localparam int unsigned VW = 32;
  localparam int unsigned DW = 2 * VW;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_COPR  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] residue;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] solution;
    logic [31:0] combined_modulus;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [VW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_DIV,
    S_LD_WAIT,
    S_LD_STORE,
    S_RD,
    S_A_DIV,
    S_A_WAIT,
    S_R1_DIV,
    S_R1_WAIT,
    S_LOOP,
    S_Q_WAIT,
    S_QT_MUL,
    S_QT_DIV,
    S_QT_WAIT,
    S_K_MUL,
    S_K_DIV,
    S_K_WAIT,
    S_TERM_MUL,
    S_SUM,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// ===== src/chinese_remainder_combiner.sv =====
// Chinese remainder combiner: loads modulus and residue pairs and solves the system.
// Each load of a nonzero modulus makes one pass of the shared 64-step divider.
// After the final pair the stored pairs are combined in turn, each with its own Euclid loop on the divider.
// Busy is high while an item is loaded or the system solved; the result is strobed for one cycle and cannot be stalled.
// Reset clears the pair count and error status and sets the product to one; the pair stores hold no reset.
// Depends on crc_pkg and crc_div.
`default_nettype none
module chinese_remainder_combiner #(
  parameter int unsigned MAX_TERMS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire crc_pkg::item_t   item_i,
  output logic                  busy,
  output logic                  done,
  output crc_pkg::result_t      result_o
);
  import crc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  state_e state_q, state_d;

  logic [VW-1:0] mod_mem [MAX_TERMS];
  logic [VW-1:0] res_mem [MAX_TERMS];

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic [VW-1:0] prod_n_q;
  logic [1:0]    flags_q;
  logic [VW-1:0] m_q, r_q, a_q, r0_q, r1_q, t0_q, t1_q, qm_q, sum_q;
  logic          last_q;
  logic [DW-1:0] mul_q;
  logic          mul_en;
  logic [VW-1:0] mul_a, mul_b;
  logic [VW-1:0] rd_mod_q, rd_res_q;
  logic [VW-1:0] t2, term, gap;
  logic          load_err;

  div_req_t div_req;
  div_rsp_t div_rsp;

  crc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign t2       = (t0_q >= div_rsp.rem) ? t0_q - div_rsp.rem
                                          : t0_q + (m_q - div_rsp.rem);
  assign term     = mul_q[VW-1:0];
  assign gap      = prod_n_q - term;
  assign load_err = (flags_q != ST_OK) || (cnt_q >= CW'(MAX_TERMS)) ||
                    (m_q != '0 && mul_q[DW-1:VW] != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start) state_d = S_LD_MUL;
      S_LD_MUL:   state_d = (m_q == '0) ? S_LD_STORE : S_LD_DIV;
      S_LD_DIV:   state_d = S_LD_WAIT;
      S_LD_WAIT:  if (div_rsp.done) state_d = S_LD_STORE;
      S_LD_STORE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (load_err) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:       state_d = S_A_DIV;
      S_A_DIV:    state_d = S_A_WAIT;
      S_A_WAIT:   if (div_rsp.done) state_d = S_R1_DIV;
      S_R1_DIV:   state_d = S_R1_WAIT;
      S_R1_WAIT:  if (div_rsp.done) state_d = S_LOOP;
      S_LOOP: begin
        if (r1_q != '0) begin
          state_d = S_Q_WAIT;
        end else if (r0_q != VW'(1)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_K_MUL;
        end
      end
      S_Q_WAIT:   if (div_rsp.done) state_d = S_QT_MUL;
      S_QT_MUL:   state_d = S_QT_DIV;
      S_QT_DIV:   state_d = S_QT_WAIT;
      S_QT_WAIT:  if (div_rsp.done) state_d = S_LOOP;
      S_K_MUL:    state_d = S_K_DIV;
      S_K_DIV:    state_d = S_K_WAIT;
      S_K_WAIT:   if (div_rsp.done) state_d = S_TERM_MUL;
      S_TERM_MUL: state_d = S_SUM;
      S_SUM:      state_d = (idx_q + 1'b1 == cnt_q) ? S_EMIT : S_RD;
      S_EMIT:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    div_req = '0;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      S_LD_MUL: begin
        mul_en = 1'b1;
        mul_a  = prod_n_q;
        mul_b  = m_q;
      end
      S_LD_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DW'(r_q);
        div_req.divisor  = m_q;
      end
      S_A_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DW'(prod_n_q);
        div_req.divisor  = rd_mod_q;
      end
      S_R1_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DW'(a_q);
        div_req.divisor  = m_q;
      end
      S_LOOP: begin
        div_req.start    = r1_q != '0;
        div_req.dividend = DW'(r0_q);
        div_req.divisor  = r1_q;
      end
      S_QT_MUL: begin
        mul_en = 1'b1;
        mul_a  = qm_q;
        mul_b  = t1_q;
      end
      S_QT_DIV, S_K_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_q;
        div_req.divisor  = m_q;
      end
      S_K_MUL: begin
        mul_en = 1'b1;
        mul_a  = rd_res_q;
        mul_b  = t0_q;
      end
      S_TERM_MUL: begin
        mul_en = 1'b1;
        mul_a  = a_q;
        mul_b  = div_rsp.rem;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) mul_q <= DW'(mul_a) * DW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LD_STORE && cnt_q < CW'(MAX_TERMS)) begin
      mod_mem[cnt_q[IW-1:0]] <= m_q;
      res_mem[cnt_q[IW-1:0]] <= r_q;
    end
    rd_mod_q <= mod_mem[idx_q[IW-1:0]];
    rd_res_q <= res_mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      prod_n_q <= VW'(1);
      flags_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_LD_MUL: begin
          if (m_q == '0) begin
            if (flags_q < ST_NOT_COPR) flags_q <= ST_NOT_COPR;
          end
        end
        S_LD_STORE: begin
          if (m_q != '0) begin
            if (mul_q[DW-1:VW] != '0) begin
              if (flags_q < ST_OVERFLOW) flags_q <= ST_OVERFLOW;
            end else begin
              prod_n_q <= mul_q[VW-1:0];
            end
          end
          if (cnt_q < CW'(MAX_TERMS)) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            flags_q <= ST_TOO_MANY;
            cnt_q   <= CW'(MAX_TERMS + 1);
          end
        end
        S_LOOP: begin
          if (r1_q == '0 && r0_q != VW'(1)) flags_q <= ST_NOT_COPR;
        end
        S_EMIT: begin
          cnt_q    <= '0;
          prod_n_q <= VW'(1);
          flags_q  <= ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        m_q    <= item_i.modulus;
        r_q    <= item_i.residue;
        last_q <= item_i.last;
        idx_q  <= '0;
        sum_q  <= '0;
      end
      S_LD_WAIT: if (div_rsp.done) r_q <= div_rsp.rem;
      S_A_DIV:   m_q <= rd_mod_q;
      S_A_WAIT:  if (div_rsp.done) a_q <= div_rsp.quot[VW-1:0];
      S_R1_WAIT: begin
        if (div_rsp.done) begin
          r0_q <= m_q;
          r1_q <= div_rsp.rem;
          t0_q <= '0;
          t1_q <= (m_q == VW'(1)) ? '0 : VW'(1);
        end
      end
      S_Q_WAIT: begin
        if (div_rsp.done) begin
          qm_q <= (div_rsp.quot == DW'(m_q)) ? '0 : div_rsp.quot[VW-1:0];
          r0_q <= r1_q;
          r1_q <= div_rsp.rem;
        end
      end
      S_QT_WAIT: begin
        if (div_rsp.done) begin
          t0_q <= t1_q;
          t1_q <= t2;
        end
      end
      S_SUM: begin
        sum_q <= (sum_q >= gap) ? sum_q - gap : sum_q + term;
        idx_q <= idx_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = state_q != S_IDLE;
  assign done = state_q == S_EMIT;

  always_comb begin
    result_o.status           = flags_q;
    result_o.solution         = (flags_q == ST_OK) ? sum_q : '0;
    result_o.combined_modulus = (flags_q == ST_OVERFLOW || flags_q == ST_TOO_MANY)
                                ? '0 : prod_n_q;
  end

endmodule
`default_nettype wire

// ===== src/crc_div.sv =====
// Restoring divider of a double-width dividend by a single-width divisor, one bit a cycle.
// Depends on crc_pkg for the request and response structs.
`default_nettype none
module crc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire crc_pkg::div_req_t req_i,
  output crc_pkg::div_rsp_t      rsp_o
);
  import crc_pkg::*;

  localparam int unsigned CNTW = $clog2(DW);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quot_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;
  logic [VW:0]     rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quot_q[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[DW-2:0], fits};
      rem_q  <= fits ? VW'(rem_sh - {1'b0, dvs_q}) : rem_sh[VW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== sim/chinese_remainder_combiner_test.sv =====
// Self-checking testbench for chinese_remainder_combiner: drives sets of modulus and
// residue pairs, predicts each solution with its own CRT solver and checks every result.
// Depends on crc_pkg and the RTL of the combiner.
`default_nettype none
module chinese_remainder_combiner_test;
  import crc_pkg::*;

  localparam int unsigned TERMS = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  item_t item_i = '0;
  logic busy;
  logic done;
  result_t result_o;

  chinese_remainder_combiner #(.MAX_TERMS(TERMS)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .done(done), .result_o(result_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state mirrors the block's set under construction.
  logic [31:0] mod_set [TERMS];
  logic [31:0] res_set [TERMS];
  int unsigned set_len;
  logic [32:0] prod;
  status_e worst;

  item_t pending_items[$];
  result_t solutions_due[$];
  int errors = 0;
  int gap_pct = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void queue_item(input item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic logic [63:0] inv_mod(input logic [63:0] a, input logic [63:0] m,
                                          output bit ok);
    logic [63:0] r0, r1, t0, t1, q, r2, qt, t2;
    r0 = m; r1 = a % m; t0 = 0; t1 = 1 % m;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      qt = ((q % m) * t1) % m;
      t2 = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    ok = (r0 == 1);
    return t0;
  endfunction

  function automatic void clear_set();
    set_len = 0; prod = 33'd1; worst = ST_OK;
  endfunction

  function automatic void raise(input status_e s);
    if (s > worst) worst = s;
  endfunction

  function automatic void solve_pair(input item_t it);
    logic [63:0] m, r, n, sum, a, inv, k, term;
    status_e st;
    bit ok;
    result_t res;
    m = 64'(it.modulus); r = 64'(it.residue);
    if (m == 0) raise(ST_NOT_COPR);
    else begin
      r = r % m;
      if (prod > 64'hFFFF_FFFF / m) raise(ST_OVERFLOW);
      else prod = 33'(prod * m);
    end
    if (set_len < TERMS) begin
      mod_set[set_len] = m[31:0]; res_set[set_len] = r[31:0]; set_len++;
    end else raise(ST_TOO_MANY);
    if (!it.last) return;
    n = 64'(prod); sum = 0; st = worst;
    if (st == ST_OK) begin
      for (int i = 0; i < set_len; i++) begin
        if (mod_set[i] == 0) begin st = ST_NOT_COPR; break; end
        a = n / mod_set[i];
        inv = inv_mod(a, 64'(mod_set[i]), ok);
        if (!ok) begin st = ST_NOT_COPR; break; end
        k = (res_set[i] * inv) % mod_set[i];
        term = a * k;
        sum = (sum >= n - term) ? sum - (n - term) : sum + term;
      end
    end
    res.solution = (st == ST_OK) ? sum[31:0] : 32'd0;
    res.combined_modulus = (st >= ST_OVERFLOW) ? 32'd0 : n[31:0];
    res.status = st;
    solutions_due = {solutions_due, res};
    clear_set();
  endfunction

  // Driver: offers the head of the queue, predicting it on the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        solve_pair(item_i);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > (start && !busy ? 1 : 0) && !hold_off &&
          $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        item_i <= pending_items[(start && !busy) ? 1 : 0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (solutions_due.size() == 0) begin
        report("unexpected result", result_o.solution, 32'd0);
      end else begin
        result_t w;
        w = solutions_due.pop_front();
        if (result_o.solution !== w.solution) report("solution", result_o.solution, w.solution);
        if (result_o.combined_modulus !== w.combined_modulus)
          report("combined_modulus", result_o.combined_modulus, w.combined_modulus);
        if (result_o.status !== w.status) report("status", result_o.status, w.status);
      end
    end
  end

  function automatic item_t mk(input logic [31:0] m, input logic [31:0] r, input logic l);
    item_t it;
    it.modulus = m; it.residue = r; it.last = l;
    return it;
  endfunction

  // Small pairwise coprime bases for well-formed random systems.
  localparam logic [31:0] PR [10] = '{3, 4, 5, 7, 11, 13, 17, 19, 23, 29};

  task automatic random_set();
    int len, kind, base, pick;
    logic [31:0] m;
    kind = $urandom_range(9);
    len = (kind == 9) ? $urandom_range(9, 11) : $urandom_range(1, 4);
    base = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      if (kind < 6 && i < 10) begin
        pick = (base + i) % 10;
        m = PR[pick] ** $urandom_range(1, (len <= 2) ? 4 : 2);
      end else if (kind == 6) m = $urandom;
      else if (kind == 7) m = $urandom_range(3) == 0 ? $urandom_range(1) : $urandom_range(2, 60);
      else m = $urandom_range(2, 1000);
      queue_item(mk(m, $urandom, i == len - 1));
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || start) @(posedge clk_i);
    while (solutions_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clear_set();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_item(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    queue_item(mk(32'd2, 32'd0, 1'b1));
    queue_item(mk(32'd3, 32'd2, 1'b0));
    queue_item(mk(32'd5, 32'd3, 1'b0));
    queue_item(mk(32'd7, 32'd2, 1'b1));
    queue_item(mk(32'd1, 32'd9, 1'b0));
    queue_item(mk(32'd11, 32'd4, 1'b1));
    queue_item(mk(32'd0, 32'd5, 1'b0));
    queue_item(mk(32'd7, 32'd1, 1'b1));
    queue_item(mk(32'd6, 32'd1, 1'b0));
    queue_item(mk(32'd9, 32'd2, 1'b1));
    queue_item(mk(32'h0001_0000, 32'd7, 1'b0));
    queue_item(mk(32'h0001_0001, 32'd8, 1'b0));
    queue_item(mk(32'd3, 32'd1, 1'b1));
    for (int i = 0; i < 9; i++)
      queue_item(mk(32'd2 * i + 33, i, i == 8));
    drain();
    hold_off = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_off = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 72 : (ph == 3 ? 22 : 0);
      while (pending_items.size() < 100) random_set();
      drain();
    end
    repeat (5000) @(posedge clk_i);
    if (errors == 0 && solutions_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
